>>> rtl/lpgl_pkg.sv
`timescale 1ns / 1ps

package lpgl_pkg;

  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned DATA_W  = 24;
  localparam int unsigned CHAN_W  = 6;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned NBUS    = 2;

  localparam logic [CMD_W-1:0] CMD_SET        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_ALL    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UPDATE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LATCH_DONE = 3'd4;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_REFUSED = 2'd1,
    KIND_CHUNK   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef logic [NBUS-1:0] cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [NBUS-1:0]    bus_mask;
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;
  } req_t;

  typedef struct packed {
    kind_e              kind;
    logic               bus;
    logic [LEVEL_W-1:0] read_level;
    logic [DATA_W-1:0]  shift_data;
    logic               extra_clock;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic  set_ch;
    logic  set_all;
    logic  latch;
    logic  mark_pend;
    logic  issue;
    kind_e op;
    logic  bus;
    logic  first;
    logic  last;
  } ctl_t;

  typedef struct packed {
    logic [NBUS-1:0] en;
    logic            pend_any;
    logic            adv;
  } sts_t;

endpackage

>>> rtl/lpgl_stream_if.sv
`timescale 1ns / 1ps

interface lpgl_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/led_pwm_grayscale_loader.sv
`timescale 1ns / 1ps

// Grayscale store and shift-out controller for two daisy-chained PWM driver buses.
// The req_i channel takes one command word per handshake: set one channel, get one
// channel, set all channels, update, or latch done. The rsp_o channel returns result
// words; the last word caused by a command has last set. The cfg_i channel writes
// bus_enable and is always ready; write it only while the block is idle.
// Set, set all, latch done and unknown commands give no word.
// A get, a refused update or an update with no enabled bus gives its word through the
// read stage and the output register. An accepted update sends one 24-bit shift word
// per cycle unless the receiver stalls, CHAINED_DRIVERS * 8 words per enabled bus,
// the first bus first; req_i stays not ready until the last word has been issued. The
// rate is set by the two-port level memory of each bus, which is read once per word.
// When the receiver stalls, the output register and one read stage fill and req_i
// drops ready; no word is lost.
// Reset sets bus_enable to 1, clears the latch pending marks, and makes every level
// read as zero at once through per-entry valid bits, so no clearing pass is needed.
module led_pwm_grayscale_loader #(
  parameter int unsigned CHAINED_DRIVERS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lpgl_stream_if.sink    req_i,
  lpgl_stream_if.source  rsp_o,
  lpgl_stream_if.sink    cfg_i
);
  import lpgl_pkg::*;

  localparam int unsigned NCHAN = CHAINED_DRIVERS * 16;
  localparam int unsigned PAIRS = NCHAN / 2;
  localparam int unsigned PW    = $clog2(PAIRS);
  localparam int unsigned AW    = PW + 1;

  ctl_t          ctl;
  sts_t          sts;
  logic [PW-1:0] pair;
  req_t          req;
  rsp_t          rsp;

  assign req         = req_i.data;
  assign cfg_i.ready = 1'b1;
  assign rsp_o.data  = rsp;

  lpgl_ctrl #(.PAIRS(PAIRS), .PW(PW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .cmd_i       (req.cmd),
    .sts_i       (sts),
    .req_ready_o (req_i.ready),
    .ctl_o       (ctl),
    .pair_o      (pair)
  );

  lpgl_dpath #(.NCHAN(NCHAN), .PW(PW), .AW(AW)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .pair_i      (pair),
    .bus_mask_i  (req.bus_mask),
    .channel_i   (req.channel),
    .level_i     (req.level),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .rsp_ready_i (rsp_o.ready),
    .sts_o       (sts),
    .rsp_valid_o (rsp_o.valid),
    .rsp_o       (rsp)
  );

endmodule

>>> rtl/lpgl_bank.sv
`timescale 1ns / 1ps

module lpgl_bank #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [lpgl_pkg::LEVEL_W-1:0] wr_data_i,
  input  logic                        fill_en_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_a_i,
  input  logic [AW-1:0]               rd_addr_b_i,
  output logic [lpgl_pkg::LEVEL_W-1:0] rd_a_o,
  output logic [lpgl_pkg::LEVEL_W-1:0] rd_b_o
);
  import lpgl_pkg::*;

  logic [LEVEL_W-1:0] mem_q [DEPTH];
  logic [LEVEL_W-1:0] rd_a_q;
  logic [LEVEL_W-1:0] rd_b_q;
  logic [DEPTH-1:0]   vld_q;
  logic [LEVEL_W-1:0] fill_q;
  logic               rv_a_q;
  logic               rv_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  // An entry that has not been written since the last fill reads as the fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      fill_q <= '0;
      rv_a_q <= 1'b0;
      rv_b_q <= 1'b0;
    end else begin
      if (fill_en_i) begin
        vld_q  <= '0;
        fill_q <= wr_data_i;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rv_a_q <= vld_q[rd_addr_a_i];
        rv_b_q <= vld_q[rd_addr_b_i];
      end
    end
  end

  assign rd_a_o = rv_a_q ? rd_a_q : fill_q;
  assign rd_b_o = rv_b_q ? rd_b_q : fill_q;

endmodule

>>> rtl/lpgl_dpath.sv
`timescale 1ns / 1ps

module lpgl_dpath #(
  parameter int unsigned NCHAN = 64,
  parameter int unsigned PW    = 5,
  parameter int unsigned AW    = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lpgl_pkg::ctl_t               ctl_i,
  input  logic [PW-1:0]                pair_i,
  input  logic [lpgl_pkg::NBUS-1:0]    bus_mask_i,
  input  logic [lpgl_pkg::CHAN_W-1:0]  channel_i,
  input  logic [lpgl_pkg::LEVEL_W-1:0] level_i,
  input  logic                         cfg_we_i,
  input  lpgl_pkg::cfg_t               cfg_data_i,
  input  logic                         rsp_ready_i,
  output lpgl_pkg::sts_t               sts_o,
  output logic                         rsp_valid_o,
  output lpgl_pkg::rsp_t               rsp_o
);
  import lpgl_pkg::*;

  localparam int unsigned CW1 = CHAN_W + 1;

  logic [NBUS-1:0]    en_q;
  logic [NBUS-1:0]    pend_q;
  logic               s1_vld_q;
  kind_e              s1_kind_q;
  logic               s1_bus_q;
  logic               s1_first_q;
  logic               s1_last_q;
  logic               s1_zero_q;
  logic               s1_src_q;
  logic               out_vld_q;
  rsp_t               rsp_q;
  rsp_t               rsp_d;
  logic               in_range;
  logic               out_free;
  logic               adv;
  logic [AW-1:0]      rd_addr_a;
  logic [AW-1:0]      rd_addr_b;
  logic [LEVEL_W-1:0] b0_a;
  logic [LEVEL_W-1:0] b0_b;
  logic [LEVEL_W-1:0] b1_a;
  logic [LEVEL_W-1:0] b1_b;

  assign in_range  = ({1'b0, channel_i} < CW1'(NCHAN));
  assign out_free  = !out_vld_q || rsp_ready_i;
  assign adv       = !s1_vld_q || out_free;
  assign rd_addr_a = (ctl_i.op == KIND_CHUNK) ? {pair_i, 1'b1} : channel_i[AW-1:0];
  assign rd_addr_b = {pair_i, 1'b0};

  lpgl_bank #(.DEPTH(NCHAN), .AW(AW)) u_bank0 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (ctl_i.set_ch && bus_mask_i[0] && in_range),
    .wr_addr_i   (channel_i[AW-1:0]),
    .wr_data_i   (level_i),
    .fill_en_i   (ctl_i.set_all && en_q[0]),
    .rd_en_i     (ctl_i.issue),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_a_o      (b0_a),
    .rd_b_o      (b0_b)
  );

  lpgl_bank #(.DEPTH(NCHAN), .AW(AW)) u_bank1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (ctl_i.set_ch && bus_mask_i[1] && in_range),
    .wr_addr_i   (channel_i[AW-1:0]),
    .wr_data_i   (level_i),
    .fill_en_i   (ctl_i.set_all && en_q[1]),
    .rd_en_i     (ctl_i.issue),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_a_o      (b1_a),
    .rd_b_o      (b1_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 2'b01;
      pend_q    <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_data_i;
      end
      if (ctl_i.mark_pend) begin
        pend_q <= pend_q | en_q;
      end else if (ctl_i.latch) begin
        pend_q <= pend_q & ~en_q;
      end
      if (adv) begin
        s1_vld_q <= ctl_i.issue;
      end
      if (out_free) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q  <= ctl_i.op;
      s1_bus_q   <= ctl_i.bus;
      s1_first_q <= ctl_i.first;
      s1_last_q  <= ctl_i.last;
      s1_zero_q  <= !in_range || (en_q == '0);
      s1_src_q   <= !en_q[0];
    end
    if (out_free && s1_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  always_comb begin
    rsp_d      = '0;
    rsp_d.kind = s1_kind_q;
    rsp_d.last = s1_last_q;
    case (s1_kind_q)
      KIND_READ: begin
        if (!s1_zero_q) begin
          rsp_d.read_level = s1_src_q ? b1_a : b0_a;
        end
      end
      KIND_CHUNK: begin
        rsp_d.bus         = s1_bus_q;
        rsp_d.extra_clock = s1_first_q;
        rsp_d.shift_data  = s1_bus_q ? {b1_a, b1_b} : {b0_a, b0_b};
      end
      default: begin
      end
    endcase
  end

  assign sts_o.en       = en_q;
  assign sts_o.pend_any = |pend_q;
  assign sts_o.adv      = adv;
  assign rsp_valid_o    = out_vld_q;
  assign rsp_o          = rsp_q;

  a_issue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.issue |-> adv)
    else $error("read issued while the read stage is blocked");

  a_mark_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.mark_pend |-> pend_q == '0)
    else $error("update started with a latch pending");

  a_mark_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.mark_pend |=> (pend_q & $past(en_q)) == $past(en_q))
    else $error("pending mark missing after update");

endmodule

>>> rtl/lpgl_ctrl.sv
`timescale 1ns / 1ps

module lpgl_ctrl #(
  parameter int unsigned PAIRS = 32,
  parameter int unsigned PW    = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic [lpgl_pkg::CMD_W-1:0] cmd_i,
  input  lpgl_pkg::sts_t             sts_i,
  output logic                       req_ready_o,
  output lpgl_pkg::ctl_t             ctl_o,
  output logic [PW-1:0]              pair_o
);
  import lpgl_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } state_e;

  localparam logic [PW-1:0] PAIR_TOP = PW'(PAIRS - 1);

  state_e        state_q;
  logic          bus_q;
  logic [PW-1:0] pair_q;
  logic          accept;
  logic          start;

  assign req_ready_o = (state_q == ST_IDLE) && sts_i.adv;
  assign accept      = req_valid_i && req_ready_o;
  assign start       = accept && (cmd_i == CMD_UPDATE) && !sts_i.pend_any &&
                       (sts_i.en != '0);
  assign pair_o      = pair_q;

  always_comb begin
    ctl_o    = '0;
    ctl_o.op = KIND_READ;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_SET:        ctl_o.set_ch = 1'b1;
            CMD_SET_ALL:    ctl_o.set_all = 1'b1;
            CMD_LATCH_DONE: ctl_o.latch = 1'b1;
            CMD_GET: begin
              ctl_o.issue = 1'b1;
              ctl_o.op    = KIND_READ;
              ctl_o.last  = 1'b1;
            end
            CMD_UPDATE: begin
              if (sts_i.pend_any) begin
                ctl_o.issue = 1'b1;
                ctl_o.op    = KIND_REFUSED;
                ctl_o.last  = 1'b1;
              end else if (sts_i.en == '0) begin
                ctl_o.issue = 1'b1;
                ctl_o.op    = KIND_NONE;
                ctl_o.last  = 1'b1;
              end else begin
                ctl_o.mark_pend = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        if (sts_i.adv) begin
          ctl_o.issue = 1'b1;
          ctl_o.op    = KIND_CHUNK;
          ctl_o.bus   = bus_q;
          ctl_o.first = (pair_q == PAIR_TOP);
          ctl_o.last  = (pair_q == '0) && (bus_q || !sts_i.en[1]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bus_q   <= 1'b0;
      pair_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_SHIFT;
            bus_q   <= !sts_i.en[0];
            pair_q  <= PAIR_TOP;
          end
        end
        ST_SHIFT: begin
          if (sts_i.adv) begin
            if (pair_q == '0) begin
              if (!bus_q && sts_i.en[1]) begin
                bus_q  <= 1'b1;
                pair_q <= PAIR_TOP;
              end else begin
                state_q <= ST_IDLE;
              end
            end else begin
              pair_q <= pair_q - 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.issue && (ctl_o.op == KIND_CHUNK) && ctl_o.last |=> state_q == ST_IDLE)
    else $error("shift sequence did not end after its last word");

  a_pair_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) && sts_i.adv && (pair_q != '0) |=>
      (state_q == ST_SHIFT) && (pair_q == $past(pair_q) - 1'b1))
    else $error("channel pair counter skipped");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lpgl_pkg::*;

  localparam int unsigned CHAINED       = 4;
  localparam int unsigned NCHAN         = CHAINED * 16;
  localparam int unsigned ITEM_TARGET   = 400;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned CYCLE_LIMIT   = 10000000;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned LEVEL_MAX     = (1 << LEVEL_W) - 1;
  localparam int unsigned CMD_MAX       = (1 << CMD_W) - 1;
  localparam int unsigned MASK_MAX      = (1 << NBUS) - 1;

  typedef enum logic [1:0] {
    STIM_WORD,
    STIM_CFG,
    STIM_SYNC
  } stim_op_e;

  typedef struct packed {
    stim_op_e op;
    req_t     word;
    cfg_t     cfg;
    logic     quiet;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lpgl_stream_if #(.T(req_t)) req_if ();
  lpgl_stream_if #(.T(rsp_t)) rsp_if ();
  lpgl_stream_if #(.T(cfg_t)) cfg_if ();

  led_pwm_grayscale_loader #(
    .CHAINED_DRIVERS(CHAINED)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  stim_t stim_q[$];
  rsp_t  pending_words[$];

  logic [LEVEL_W-1:0] level_store[NBUS][NCHAN];
  logic [NBUS-1:0]    latch_pend;
  cfg_t               bus_en;

  logic req_fire  = 1'b0;
  logic cfg_fire  = 1'b0;
  logic quiet     = 1'b0;
  logic stim_done = 1'b0;

  int queued_items = 0;
  int errors       = 0;
  int n_cmds       = 0;
  int n_cfg        = 0;
  int n_reads      = 0;
  int n_chunks     = 0;
  int n_refused    = 0;
  int n_empty      = 0;

  task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [NBUS-1:0] mask,
                          input logic [CHAN_W-1:0] ch, input logic [LEVEL_W-1:0] lvl);
    stim_t s;
    s = '0;
    s.op = STIM_WORD;
    s.word.cmd = cmd;
    s.word.bus_mask = mask;
    s.word.channel = ch;
    s.word.level = lvl;
    stim_q.push_back(s);
    queued_items++;
  endtask

  task automatic add_random(input logic [CMD_W-1:0] cmd);
    add_item(cmd, NBUS'($urandom_range(0, MASK_MAX)), CHAN_W'($urandom_range(0, NCHAN - 1)),
             LEVEL_W'($urandom_range(0, LEVEL_MAX)));
  endtask

  task automatic add_cfg(input cfg_t v);
    stim_t s;
    s = '0;
    s.op = STIM_CFG;
    s.cfg = v;
    stim_q.push_back(s);
  endtask

  // Hold the sender until every expected word has come back and the block has settled.
  task automatic add_sync(input logic q);
    stim_t s;
    s = '0;
    s.op = STIM_SYNC;
    s.quiet = q;
    stim_q.push_back(s);
  endtask

  function automatic rsp_t make_word(kind_e k, logic b, logic [LEVEL_W-1:0] rd,
                                     logic [DATA_W-1:0] d, logic x, logic l);
    rsp_t r;
    r.kind = k;
    r.bus = b;
    r.read_level = rd;
    r.shift_data = d;
    r.extra_clock = x;
    r.last = l;
    return r;
  endfunction

  task automatic predict_command(input req_t w);
    rsp_t               r;
    int                 n;
    logic [LEVEL_W-1:0] rd;
    n = 0;
    rd = '0;
    case (w.cmd)
      CMD_SET: begin
        if (w.channel < NCHAN) begin
          for (int b = 0; b < NBUS; b++) begin
            if (w.bus_mask[b]) level_store[b][w.channel] = w.level;
          end
        end
      end
      CMD_GET: begin
        if (w.channel < NCHAN) begin
          if (bus_en[0]) rd = level_store[0][w.channel];
          else if (bus_en[1]) rd = level_store[1][w.channel];
        end
        pending_words.push_back(make_word(KIND_READ, 1'b0, rd, '0, 1'b0, 1'b1));
      end
      CMD_SET_ALL: begin
        for (int b = 0; b < NBUS; b++) begin
          if (bus_en[b]) begin
            for (int i = 0; i < NCHAN; i++) level_store[b][i] = w.level;
          end
        end
      end
      CMD_UPDATE: begin
        if (|latch_pend) begin
          pending_words.push_back(make_word(KIND_REFUSED, 1'b0, '0, '0, 1'b0, 1'b1));
        end else begin
          for (int b = 0; b < NBUS; b++) begin
            if (bus_en[b]) begin
              for (int c = NCHAN; c >= 2; c -= 2) begin
                pending_words.push_back(make_word(KIND_CHUNK, 1'(b), '0,
                                                  {level_store[b][c-1], level_store[b][c-2]},
                                                  c == NCHAN, 1'b0));
                n++;
              end
              latch_pend[b] = 1'b1;
            end
          end
          if (n == 0) begin
            pending_words.push_back(make_word(KIND_NONE, 1'b0, '0, '0, 1'b0, 1'b1));
          end else begin
            r = pending_words.pop_back();
            r.last = 1'b1;
            pending_words.push_back(r);
          end
        end
      end
      CMD_LATCH_DONE: begin
        for (int b = 0; b < NBUS; b++) begin
          if (bus_en[b]) latch_pend[b] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_word(input rsp_t got);
    rsp_t w;
    if (pending_words.size() == 0) begin
      errors++;
      if (errors <= REPORT_MAX)
        $display("unexpected word: kind=%0d bus=%0d rd=%h data=%h extra=%0d last=%0d",
                 got.kind, got.bus, got.read_level, got.shift_data, got.extra_clock, got.last);
    end else begin
      w = pending_words.pop_front();
      case (w.kind)
        KIND_READ:    n_reads++;
        KIND_CHUNK:   n_chunks++;
        KIND_REFUSED: n_refused++;
        default:      n_empty++;
      endcase
      if (got.kind !== w.kind || got.bus !== w.bus || got.read_level !== w.read_level ||
          got.shift_data !== w.shift_data || got.extra_clock !== w.extra_clock ||
          got.last !== w.last) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: expected kind=%0d bus=%0d rd=%h data=%h extra=%0d last=%0d, %s",
                   w.kind, w.bus, w.read_level, w.shift_data, w.extra_clock, w.last,
                   $sformatf("got kind=%0d bus=%0d rd=%h data=%h extra=%0d last=%0d",
                             got.kind, got.bus, got.read_level, got.shift_data,
                             got.extra_clock, got.last));
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_fire <= req_if.valid && req_if.ready;
      cfg_fire <= cfg_if.valid && cfg_if.ready;
      if (rsp_if.valid && rsp_if.ready) check_word(rsp_if.data);
      if (cfg_if.valid && cfg_if.ready) begin
        bus_en = cfg_if.data;
        n_cfg++;
      end
      if (req_if.valid && req_if.ready) begin
        predict_command(req_if.data);
        n_cmds++;
      end
    end
  end

  stim_t cur;
  logic  next_req_valid;
  logic  next_cfg_valid;
  req_t  next_word;
  cfg_t  next_cfg;
  int    gap_left     = 0;
  int    settle_count = 0;
  logic  syncing      = 1'b0;

  always @(negedge clk_i) begin
    next_req_valid = req_if.valid;
    next_cfg_valid = cfg_if.valid;
    next_word = req_if.data;
    next_cfg = cfg_if.data;
    if (!rst_ni) begin
      next_req_valid = 1'b0;
      next_cfg_valid = 1'b0;
    end else begin
      if (next_req_valid && req_fire) next_req_valid = 1'b0;
      if (next_cfg_valid && cfg_fire) next_cfg_valid = 1'b0;
      if (!next_req_valid && !next_cfg_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (syncing) begin
          if (pending_words.size() == 0) settle_count++;
          else settle_count = 0;
          if (settle_count >= SETTLE_CYCLES) syncing = 1'b0;
        end else if (stim_q.size() != 0) begin
          cur = stim_q.pop_front();
          case (cur.op)
            STIM_WORD: begin
              next_req_valid = 1'b1;
              next_word = cur.word;
              gap_left = pick_gap();
            end
            STIM_CFG: begin
              next_cfg_valid = 1'b1;
              next_cfg = cur.cfg;
            end
            default: begin
              syncing = 1'b1;
              settle_count = 0;
              quiet <= cur.quiet;
            end
          endcase
        end else begin
          stim_done <= 1'b1;
        end
      end
    end
    req_if.valid <= next_req_valid;
    req_if.data <= next_word;
    cfg_if.valid <= next_cfg_valid;
    cfg_if.data <= next_cfg;
  end

  int   ready_left = 0;
  logic next_ready;

  always @(negedge clk_i) begin
    next_ready = rsp_if.ready;
    if (ready_left > 0) begin
      ready_left--;
    end else if (quiet || !rst_ni) begin
      next_ready = 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:64]: begin
          next_ready = 1'b1;
          ready_left = $urandom_range(0, 11);
        end
        [65:91]: begin
          next_ready = 1'b0;
          ready_left = $urandom_range(0, 2);
        end
        default: begin
          next_ready = 1'b0;
          ready_left = $urandom_range(15, 50);
        end
      endcase
    end
    rsp_if.ready <= next_ready;
  end

  initial begin
    int waited;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    bus_en = cfg_t'(1);
    latch_pend = '0;
    for (int b = 0; b < NBUS; b++) begin
      for (int i = 0; i < NCHAN; i++) level_store[b][i] = '0;
    end

    add_sync(1'b0);
    add_cfg(cfg_t'(1));
    add_item(CMD_GET, 2'd0, '0, '0);
    add_item(CMD_SET, 2'd3, '0, LEVEL_W'(LEVEL_MAX));
    add_item(CMD_SET, 2'd1, CHAN_W'(NCHAN - 1), 12'hABC);
    add_item(CMD_SET, 2'd2, CHAN_W'(NCHAN - 1), 12'h123);
    add_item(CMD_GET, 2'd0, CHAN_W'(NCHAN - 1), '0);
    add_item(CMD_UPDATE, 2'd0, '0, '0);
    add_item(CMD_UPDATE, 2'd3, '0, '0);
    add_item(CMD_LATCH_DONE, 2'd0, '0, '0);
    add_item(CMD_SET_ALL, 2'd0, '0, 12'h5A5);
    for (int c = CMD_LATCH_DONE + 1; c <= CMD_MAX; c++) add_random(CMD_W'(c));
    add_item(CMD_GET, 2'd3, 6'd10, LEVEL_W'(LEVEL_MAX));

    add_sync(1'b0);
    add_cfg(cfg_t'(3));
    add_item(CMD_UPDATE, 2'd0, '0, '0);
    add_item(CMD_LATCH_DONE, 2'd0, '0, '0);
    add_item(CMD_GET, 2'd0, CHAN_W'(NCHAN - 1), '0);

    // Leave a latch pending on the second bus, then disable it so latch done misses it.
    add_sync(1'b0);
    add_cfg(cfg_t'(2));
    add_item(CMD_GET, 2'd0, CHAN_W'(NCHAN - 1), '0);
    add_item(CMD_SET, 2'd0, 6'd5, 12'h001);
    add_item(CMD_UPDATE, 2'd0, '0, '0);
    add_sync(1'b1);
    add_cfg(cfg_t'(1));
    add_item(CMD_LATCH_DONE, 2'd0, '0, '0);
    add_item(CMD_UPDATE, 2'd0, '0, '0);
    add_sync(1'b0);
    add_cfg(cfg_t'(2));
    add_item(CMD_LATCH_DONE, 2'd0, '0, '0);
    add_sync(1'b0);
    add_cfg(cfg_t'(0));
    add_item(CMD_UPDATE, 2'd0, '0, '0);
    add_item(CMD_SET_ALL, 2'd0, '0, LEVEL_W'(LEVEL_MAX));
    add_item(CMD_GET, 2'd0, 6'd5, '0);

    while (queued_items < ITEM_TARGET) begin
      add_sync($urandom_range(0, 5) == 0);
      add_cfg(cfg_t'($urandom_range(0, MASK_MAX)));
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(3, 10)) add_random(CMD_W'($urandom_range(0, CMD_MAX)));
        end else begin
          repeat ($urandom_range(1, 6)) add_random(CMD_SET);
          if ($urandom_range(0, 4) == 0) add_random(CMD_SET_ALL);
          repeat ($urandom_range(1, 3)) add_random(CMD_GET);
          add_random(CMD_UPDATE);
          if ($urandom_range(0, 9) < 7) add_random(CMD_LATCH_DONE);
        end
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    waited = 0;
    while ((!stim_done || pending_words.size() != 0) && waited < CYCLE_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (waited >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d words outstanding", waited,
               pending_words.size());
      $display("Verification failed");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk_i);
      if (pending_words.size() != 0) begin
        errors += pending_words.size();
        $display("%0d expected words never arrived", pending_words.size());
      end
      $display("Ran %0d commands and %0d bus enable writes in %0d cycles.", n_cmds, n_cfg,
               waited);
      $display("Returned %0d reads, %0d shift chunks, %0d refused and %0d empty updates.",
               n_reads, n_chunks, n_refused, n_empty);
      if (errors == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
      $finish;
    end
  end

endmodule
